[sv/float_power_by_squaring_defines.svh]
// Assertion macros used by the float power-by-squaring controller.
`ifndef FLOAT_POWER_BY_SQUARING_DEFINES_SVH
`define FLOAT_POWER_BY_SQUARING_DEFINES_SVH

// Same-cycle implication, checked on i_clk and disabled while in reset.
`define FPBS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while in reset.
`define FPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fpbs_pkg.sv]
// Package with the types, constants and rounding function of the float power block.
`default_nettype none

package fpbs_pkg;

    localparam int unsigned FP_W      = 64;
    localparam int unsigned EXP_IN_W  = 32;
    localparam int unsigned MAG_W     = EXP_IN_W + 1;
    localparam int unsigned MAN_W     = 53;
    localparam int unsigned PROD_W    = 2 * MAN_W;
    localparam int unsigned SE_W      = 14;
    localparam int unsigned PP_W      = 32;
    localparam int unsigned DIV_STEPS = MAN_W + 2;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [FP_W-1:0] C_ONE       = 64'h3FF0_0000_0000_0000;
    localparam logic [FP_W-1:0] C_DEF_NAN   = 64'hFFF8_0000_0000_0000;
    localparam logic [FP_W-1:0] C_QUIET_BIT = 64'h0008_0000_0000_0000;

    // Operation that the datapath runs on its shared floating-point unit.
    typedef enum logic [1:0] {
        DP_MUL_ACC,
        DP_SQUARE,
        DP_RECIP
    } t_dp_op;

    // Operation of the floating-point unit itself.
    typedef enum logic {
        FPU_MUL,
        FPU_RCP
    } t_fpu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECIP,
        S_WAIT_RCP,
        S_STEP,
        S_WAIT_MUL,
        S_SHIFT,
        S_WAIT_SQR,
        S_FINISH
    } t_ctrl_state;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_MULT,
        F_DIV,
        F_ALIGN,
        F_ROUND
    } t_fpu_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;
        logic   start;
        t_dp_op op;
        logic   shift_mag;
        logic   load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_zero;
        logic exp_neg;
        logic mag_lsb;
        logic mag_last;
        logic fpu_done;
    } t_dp_sts;

    // Rounds a significand with its leading one at the top bit to nearest even and packs
    // it as binary64. Exponents at or below zero take the subnormal path.
    function automatic logic [FP_W-1:0] fpbs_round_pack(
        input logic                   sign,
        input logic signed [SE_W-1:0] e,
        input logic [PROD_W-1:0]      x
    );
        logic [SE_W-1:0]          sh;
        logic [6:0]               shc;
        logic [PROD_W-1:0]        xs;
        logic [PROD_W-1:0]        mask;
        logic [MAN_W-1:0]         kept;
        logic                     g;
        logic                     s;
        logic [MAN_W:0]           m;
        logic signed [SE_W-1:0]   en;
        logic [FP_W-1:0]          r;
        sh   = (e <= 14'sd0) ? SE_W'(14'sd1 - e) : '0;
        shc  = (sh > 14'd107) ? 7'd107 : sh[6:0];
        xs   = x >> shc;
        mask = ~({PROD_W{1'b1}} << shc);
        kept = xs[PROD_W-1 -: MAN_W];
        g    = xs[PROD_W-1-MAN_W];
        s    = (|xs[PROD_W-2-MAN_W:0]) | (|(x & mask));
        m    = {1'b0, kept} + (MAN_W+1)'(g & (s | kept[0]));
        en   = e + $signed({{(SE_W-1){1'b0}}, m[MAN_W]});
        if (e <= 14'sd0) begin
            r = {sign, {10'd0, m[MAN_W-1]}, m[MAN_W-2:0]};
        end else if (en >= 14'sd2047) begin
            r = {sign, 11'h7FF, 52'd0};
        end else begin
            r = {sign, en[10:0], m[MAN_W] ? 52'd0 : m[MAN_W-2:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/fpbs_if.sv]
// Stream interfaces for the input and result channels.
`default_nettype none

interface fpbs_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] base_bits;
    logic [31:0] exponent;

    modport source (output valid, output base_bits, output exponent, input ready);
    modport sink   (input valid, input base_bits, input exponent, output ready);
endinterface

interface fpbs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] power_bits;

    modport source (output valid, output power_bits, input ready);
    modport sink   (input valid, input power_bits, output ready);
endinterface

`default_nettype wire

[sv/fpbs_fpu.sv]
// Multi-cycle binary64 unit: multiply a by b, or reciprocal of b.
`default_nettype none

module fpbs_fpu
    import fpbs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire t_fpu_op         i_op,
    input  wire logic [FP_W-1:0] i_a,
    input  wire logic [FP_W-1:0] i_b,
    output logic                 o_done,
    output logic [FP_W-1:0]      o_result
);

    t_fpu_state               r_state, n_state;
    t_fpu_op                  r_op, n_op;
    logic                     r_sign, n_sign;
    logic [MAN_W-1:0]         r_ma, n_ma, r_mb, n_mb;
    logic signed [SE_W-1:0]   r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [PROD_W-1:0]        r_prod, n_prod, r_x, n_x;
    logic [MAN_W:0]           r_rem, n_rem;
    logic [DIV_STEPS-1:0]     r_quo, n_quo;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [FP_W-1:0]          r_result, n_result;
    logic                     r_done, n_done;

    // Operand classification.
    logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    assign a_nan  = (&i_a[62:52]) &  (|i_a[51:0]);
    assign a_inf  = (&i_a[62:52]) & ~(|i_a[51:0]);
    assign a_zero = ~(|i_a[62:0]);
    assign b_nan  = (&i_b[62:52]) &  (|i_b[51:0]);
    assign b_inf  = (&i_b[62:52]) & ~(|i_b[51:0]);
    assign b_zero = ~(|i_b[62:0]);

    // Partial-product operands: the low 32 bits and the high 21 bits of the significands, each as 32 bits.
    logic [PP_W-1:0]   pp_a, pp_b;
    logic [2*PP_W-1:0] pp;
    logic [6:0]        pp_sh;
    assign pp_a  = r_cnt[1] ? PP_W'(r_ma[MAN_W-1:PP_W]) : r_ma[PP_W-1:0];
    assign pp_b  = r_cnt[0] ? PP_W'(r_mb[MAN_W-1:PP_W]) : r_mb[PP_W-1:0];
    assign pp    = pp_a * pp_b;
    assign pp_sh = (r_cnt[1:0] == 2'd0) ? 7'd0 : ((r_cnt[1:0] == 2'd3) ? 7'd64 : 7'd32);

    // One restoring division step.
    logic           div_ge;
    logic [MAN_W:0] div_diff;
    assign div_ge   = r_rem >= {1'b0, r_mb};
    assign div_diff = r_rem - {1'b0, r_mb};

    // Next-state logic of the unit.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_sign   = r_sign;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_ea     = r_ea;
        n_eb     = r_eb;
        n_e      = r_e;
        n_prod   = r_prod;
        n_x      = r_x;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_result = r_result;
        n_done   = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_op   = i_op;
                    n_ma   = (i_a[62:52] == 11'd0) ? {1'b0, i_a[51:0]} : {1'b1, i_a[51:0]};
                    n_mb   = (i_b[62:52] == 11'd0) ? {1'b0, i_b[51:0]} : {1'b1, i_b[51:0]};
                    n_ea   = (i_a[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, i_a[62:52]});
                    n_eb   = (i_b[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, i_b[62:52]});
                    n_state = F_NORM;
                    if (i_op == FPU_MUL) begin
                        n_sign = i_a[63] ^ i_b[63];
                        // Special operands are settled at once.
                        if (a_nan) begin
                            n_result = i_a | C_QUIET_BIT;
                            n_done   = 1'b1;
                            n_state  = F_IDLE;
                        end else if (b_nan) begin
                            n_result = i_b | C_QUIET_BIT;
                            n_done   = 1'b1;
                            n_state  = F_IDLE;
                        end else if ((a_inf & b_zero) | (a_zero & b_inf)) begin
                            n_result = C_DEF_NAN;
                            n_done   = 1'b1;
                            n_state  = F_IDLE;
                        end else if (a_inf | b_inf) begin
                            n_result = {n_sign, 11'h7FF, 52'd0};
                            n_done   = 1'b1;
                            n_state  = F_IDLE;
                        end else if (a_zero | b_zero) begin
                            n_result = {n_sign, 63'd0};
                            n_done   = 1'b1;
                            n_state  = F_IDLE;
                        end
                    end else begin
                        n_sign = i_b[63];
                        n_ma   = {1'b1, 52'd0};
                        if (b_nan) begin
                            n_result = i_b | C_QUIET_BIT;
                            n_done   = 1'b1;
                            n_state  = F_IDLE;
                        end else if (b_inf) begin
                            n_result = {n_sign, 63'd0};
                            n_done   = 1'b1;
                            n_state  = F_IDLE;
                        end else if (b_zero) begin
                            n_result = {n_sign, 11'h7FF, 52'd0};
                            n_done   = 1'b1;
                            n_state  = F_IDLE;
                        end
                    end
                end
            end
            F_NORM: begin
                // Subnormal significands move up one bit a cycle.
                if (r_ma[MAN_W-1] & r_mb[MAN_W-1]) begin
                    n_cnt = '0;
                    if (r_op == FPU_MUL) begin
                        n_prod  = '0;
                        n_state = F_MULT;
                    end else begin
                        n_rem   = (MAN_W+1)'({1'b1, 52'd0});
                        n_quo   = '0;
                        n_state = F_DIV;
                    end
                end else begin
                    if (!r_ma[MAN_W-1]) begin
                        n_ma = r_ma << 1;
                        n_ea = r_ea - 14'sd1;
                    end
                    if (!r_mb[MAN_W-1]) begin
                        n_mb = r_mb << 1;
                        n_eb = r_eb - 14'sd1;
                    end
                end
            end
            F_MULT: begin
                n_prod = r_prod + (PROD_W'(pp) << pp_sh);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = F_ALIGN;
                end
            end
            F_DIV: begin
                n_quo = {r_quo[DIV_STEPS-2:0], div_ge};
                n_rem = (div_ge ? div_diff : r_rem) << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = F_ALIGN;
                end
            end
            F_ALIGN: begin
                // Put the leading one at the top and fix the exponent.
                if (r_op == FPU_MUL) begin
                    n_x = r_prod[PROD_W-1] ? r_prod : (r_prod << 1);
                    n_e = r_ea + r_eb - 14'sd1023 +
                          $signed({{(SE_W-1){1'b0}}, r_prod[PROD_W-1]});
                end else begin
                    n_x = r_quo[DIV_STEPS-1] ? {r_quo, 51'd0} : {r_quo[DIV_STEPS-2:0], 52'd0};
                    n_x[0] = n_x[0] | (|r_rem);
                    n_e = 14'sd2046 - r_eb -
                          $signed({{(SE_W-1){1'b0}}, ~r_quo[DIV_STEPS-1]});
                end
                n_state = F_ROUND;
            end
            F_ROUND: begin
                n_result = fpbs_round_pack(r_sign, r_e, r_x);
                n_done   = 1'b1;
                n_state  = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_sign   <= n_sign;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_ea     <= n_ea;
        r_eb     <= n_eb;
        r_e      <= n_e;
        r_prod   <= n_prod;
        r_x      <= n_x;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

[sv/fpbs_datapath.sv]
// Datapath: base, running product and exponent magnitude around the shared unit.
`default_nettype none

module fpbs_datapath
    import fpbs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [FP_W-1:0]     i_base_bits,
    input  wire logic [EXP_IN_W-1:0] i_exponent,
    output t_dp_sts                  o_sts,
    output logic [FP_W-1:0]          o_power_bits
);

    logic [FP_W-1:0]  r_base, r_acc, r_out;
    logic [MAG_W-1:0] r_mag;
    t_dp_op           r_op;

    logic            fpu_done;
    logic [FP_W-1:0] fpu_result;
    t_fpu_op         fpu_op;
    logic [FP_W-1:0] fpu_a;

    // Operand selection for the shared unit.
    assign fpu_op = (i_cmd.op == DP_RECIP) ? FPU_RCP : FPU_MUL;
    assign fpu_a  = (i_cmd.op == DP_MUL_ACC) ? r_acc : r_base;

    fpbs_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start),
        .i_op     (fpu_op),
        .i_a      (fpu_a),
        .i_b      (r_base),
        .o_done   (fpu_done),
        .o_result (fpu_result)
    );

    // Operand registers, written on load and when the unit finishes; the op is taken on start, the output on load_out.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op <= i_cmd.op;
        end
        if (i_cmd.load) begin
            r_base <= i_base_bits;
            r_acc  <= C_ONE;
            r_mag  <= i_exponent[EXP_IN_W-1] ? (MAG_W'(0) - {1'b1, i_exponent})
                                             : {1'b0, i_exponent};
        end else begin
            if (fpu_done) begin
                if (r_op == DP_MUL_ACC) begin
                    r_acc <= fpu_result;
                end else begin
                    r_base <= fpu_result;
                end
            end
            if (i_cmd.shift_mag) begin
                r_mag <= r_mag >> 1;
            end
        end
        if (i_cmd.load_out) begin
            r_out <= r_acc;
        end
    end

    // Status toward the controller.
    assign o_sts.exp_zero = ~(|i_exponent);
    assign o_sts.exp_neg  = i_exponent[EXP_IN_W-1];
    assign o_sts.mag_lsb  = r_mag[0];
    assign o_sts.mag_last = ~(|r_mag[MAG_W-1:1]);
    assign o_sts.fpu_done = fpu_done;

    assign o_power_bits = r_out;

endmodule

`default_nettype wire

[sv/fpbs_ctrl.sv]
// Controller state machine that sequences reciprocal, multiplies and squarings.
`default_nettype none
`include "float_power_by_squaring_defines.svh"

module fpbs_ctrl
    import fpbs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        in_xfer;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid & o_in_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid & ~i_out_ready;
        o_cmd.load      = 1'b0;
        o_cmd.start     = 1'b0;
        o_cmd.op        = DP_SQUARE;
        o_cmd.shift_mag = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.exp_zero) begin
                        n_state = S_FINISH;
                    end else if (i_sts.exp_neg) begin
                        n_state = S_RECIP;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_RECIP: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = DP_RECIP;
                n_state     = S_WAIT_RCP;
            end
            S_WAIT_RCP: begin
                o_cmd.op = DP_RECIP;
                if (i_sts.fpu_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (i_sts.mag_lsb) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = DP_MUL_ACC;
                    n_state     = S_WAIT_MUL;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_WAIT_MUL: begin
                o_cmd.op = DP_MUL_ACC;
                if (i_sts.fpu_done) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // Shift the magnitude; after the last set bit no further squaring is needed.
                o_cmd.shift_mag = 1'b1;
                if (i_sts.mag_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = DP_SQUARE;
                    n_state     = S_WAIT_SQR;
                end
            end
            S_WAIT_SQR: begin
                if (i_sts.fpu_done) begin
                    n_state = S_STEP;
                end
            end
            S_FINISH: begin
                // Move the product to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `FPBS_ASSERT_NEXT(a_zero_exp_finishes, in_xfer && i_sts.exp_zero, r_state == S_FINISH, "zero exponent did not go straight to finish")
    `FPBS_ASSERT_IMPL(a_done_while_waiting, i_sts.fpu_done, (r_state == S_WAIT_RCP) || (r_state == S_WAIT_MUL) || (r_state == S_WAIT_SQR), "unit finished outside a wait state")
    `FPBS_ASSERT_NEXT(a_finish_delivers, (r_state == S_FINISH) && (!r_out_valid || i_out_ready), o_out_valid && (r_state == S_IDLE), "finished product not presented")

endmodule

`default_nettype wire

[sv/float_power_by_squaring.sv]
// Top level of the binary64 integer power unit.
//
//  channel  | modport | payload                          | transfer when
//  i_req    | sink    | base_bits[63:0], exponent[31:0]  | valid & ready
//  o_rsp    | source  | power_bits[63:0]                 | valid & ready
//
// One item is worked at a time on a single shared binary64 multiply/reciprocal unit.
// Multiplies and reciprocals are iterative, after a subnormal operand's significand is
// shifted up per leading zero. Each exponent bit below the top costs a squaring, plus a
// multiply when set; the top bit costs a multiply and a negative exponent a reciprocal.
// Reset is synchronous and active low and clears only the control state.
// The result waits in an output register; the next item is taken once it is produced.
`default_nettype none

module float_power_by_squaring
    import fpbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpbs_in_if.sink   i_req,
    fpbs_out_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    fpbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fpbs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_base_bits  (i_req.base_bits),
        .i_exponent   (i_req.exponent),
        .o_sts        (sts),
        .o_power_bits (o_rsp.power_bits)
    );

endmodule

`default_nettype wire
